FILE: hw/rtl/improved_perlin_noise_3d_assert.svh
// ----------------------------------------------------------------
// improved_perlin_noise_3d assertion macros
// Concurrent check macros, empty when SYNTH is set.
// ----------------------------------------------------------------
`ifndef IMPROVED_PERLIN_NOISE_3D_ASSERT_SVH
`define IMPROVED_PERLIN_NOISE_3D_ASSERT_SVH
`ifndef SYNTH
`define IPN_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("ipn check failed: same cycle");
`define IPN_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("ipn check failed: next cycle");
`else
`define IPN_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define IPN_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

FILE: hw/rtl/ipn_pkg.sv
// ----------------------------------------------------------------
// ipn_pkg
// Shared widths, codes and control types of the noise sampler.
// ----------------------------------------------------------------
package ipn_pkg;

	localparam int POS_W     = 48;
	localparam int ORG_W     = 24;
	localparam int TAB_AW    = 8;
	localparam int TAB_DEPTH = 256;
	localparam int BYTE_W    = 8;
	localparam int OUT_W     = 18;
	localparam int ACC_W     = 32;
	localparam int CFG_AW    = 2;
	localparam int NSTG      = 13;
	localparam int NCORNER   = 8;

	localparam logic signed [ACC_W-1:0] OUT_MAX = 32'sd131071;
	localparam logic signed [ACC_W-1:0] OUT_MIN = -32'sd131072;

	typedef enum logic [0:0] {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_ORIGIN_X = 2'd0,
		CFG_ORIGIN_Y = 2'd1,
		CFG_ORIGIN_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic sample;
	} ctl_t;

	typedef struct packed {
		logic              wr;
		logic [TAB_AW-1:0] idx;
		logic [BYTE_W-1:0] data;
	} tab_wr_t;

endpackage

FILE: hw/rtl/ipn_if.sv
// ----------------------------------------------------------------
// ipn_in_if / ipn_out_if
// Valid/ready channels for sample items and noise results.
// ----------------------------------------------------------------
interface ipn_in_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [ipn_pkg::BYTE_W-1:0]          entry_index;
	logic [ipn_pkg::BYTE_W-1:0]          entry_value;
	logic signed [ipn_pkg::POS_W-1:0]    pos_x;
	logic signed [ipn_pkg::POS_W-1:0]    pos_y;
	logic signed [ipn_pkg::POS_W-1:0]    pos_z;

	modport source (output valid, op, entry_index, entry_value, pos_x, pos_y, pos_z,
		input ready);
	modport sink (input valid, op, entry_index, entry_value, pos_x, pos_y, pos_z,
		output ready);
endinterface

interface ipn_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [ipn_pkg::OUT_W-1:0] noise_value;
	logic                             is_sample;

	modport source (output valid, noise_value, is_sample, input ready);
	modport sink (input valid, noise_value, is_sample, output ready);
endinterface

FILE: hw/rtl/improved_perlin_noise_3d.sv
// ----------------------------------------------------------------
// improved_perlin_noise_3d
// Throughput: one item per cycle while result.ready is high or the output
// is empty; thirteen register stages set by four fade multiplies and three
// interpolation levels, with seven table copies.
// Reset clears valid bits and origins; the table needs no clearing pass.
// ----------------------------------------------------------------
`include "improved_perlin_noise_3d_assert.svh"

module improved_perlin_noise_3d #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ipn_in_if.sink                       item,
	ipn_out_if.source                    result,
	input  logic                         cfg_we,
	input  logic [ipn_pkg::CFG_AW-1:0]   cfg_idx,
	input  logic [ipn_pkg::ORG_W-1:0]    cfg_wdata
);

	localparam int AW = ipn_pkg::TAB_AW;

	logic [ipn_pkg::ORG_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	ipn_pkg::ctl_t             ctl_s [1:ipn_pkg::NSTG];
	ipn_pkg::tab_wr_t          wr_s1;
	logic                      adv;

	logic [AW-1:0]             xi, yi, zi;
	logic [FRAC_BITS-1:0]      fx, fy, fz;
	logic [AW-1:0]             xi_s1, yi_s1, zi_s1;
	logic [AW-1:0]             eidx_s1;
	logic [ipn_pkg::BYTE_W-1:0] eval_s1;
	logic [FRAC_BITS-1:0]      fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2;
	logic [FRAC_BITS-1:0]      fx_s3, fy_s3, fz_s3, fx_s4, fy_s4, fz_s4;
	logic [FRAC_BITS:0]        fu_s6, fv_s6, fw_s6;
	logic [ipn_pkg::BYTE_W-1:0] h_s4 [ipn_pkg::NCORNER];
	logic signed [FRAC_BITS+3:0] r_s12;
	logic signed [ipn_pkg::ACC_W-1:0] r_ext;
	logic signed [ipn_pkg::ACC_W-1:0] r_sat;
	logic signed [ipn_pkg::OUT_W-1:0] noise_s13;

	assign adv          = !ctl_s[ipn_pkg::NSTG].valid || result.ready;
	assign item.ready   = adv;
	assign result.valid = ctl_s[ipn_pkg::NSTG].valid;
	assign result.noise_value = noise_s13;
	assign result.is_sample   = ctl_s[ipn_pkg::NSTG].sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
		end else if (cfg_we) begin
			unique case (ipn_pkg::cfg_reg_t'(cfg_idx))
				ipn_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_wdata;
				ipn_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				ipn_pkg::CFG_ORIGIN_Z: origin_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ipn_axis_split #(.FRAC_BITS(FRAC_BITS)) u_split_x (
		.pos(item.pos_x), .origin(origin_x_q), .ip_lo(xi), .frac(fx));
	ipn_axis_split #(.FRAC_BITS(FRAC_BITS)) u_split_y (
		.pos(item.pos_y), .origin(origin_y_q), .ip_lo(yi), .frac(fy));
	ipn_axis_split #(.FRAC_BITS(FRAC_BITS)) u_split_z (
		.pos(item.pos_z), .origin(origin_z_q), .ip_lo(zi), .frac(fz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ipn_pkg::NSTG; i++) begin
				ctl_s[i] <= '0;
			end
		end else if (adv) begin
			ctl_s[1].valid  <= item.valid;
			ctl_s[1].sample <= (ipn_pkg::op_t'(item.op) == ipn_pkg::OP_SAMPLE);
			for (int i = 2; i <= ipn_pkg::NSTG; i++) begin
				ctl_s[i] <= ctl_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xi_s1   <= xi;
			yi_s1   <= yi;
			zi_s1   <= zi;
			eidx_s1 <= item.entry_index;
			eval_s1 <= item.entry_value;
			fx_s1   <= fx;
			fy_s1   <= fy;
			fz_s1   <= fz;
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
			fz_s2   <= fz_s1;
			fx_s3   <= fx_s2;
			fy_s3   <= fy_s2;
			fz_s3   <= fz_s2;
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
			fz_s4   <= fz_s3;
			noise_s13 <= ctl_s[ipn_pkg::NSTG-1].sample ? r_sat[ipn_pkg::OUT_W-1:0] : '0;
		end
	end

	assign wr_s1.wr   = ctl_s[1].valid && !ctl_s[1].sample;
	assign wr_s1.idx  = eidx_s1;
	assign wr_s1.data = eval_s1;

	ipn_perm_hash u_hash (
		.clk(clk), .arst_n(arst_n), .en(adv), .wr_s1(wr_s1),
		.xi_s1(xi_s1), .yi_s1(yi_s1), .zi_s1(zi_s1), .h_s4(h_s4));

	ipn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_u (
		.clk(clk), .en(adv), .t_s1(fx_s1), .fade_s6(fu_s6));
	ipn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_v (
		.clk(clk), .en(adv), .t_s1(fy_s1), .fade_s6(fv_s6));
	ipn_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_w (
		.clk(clk), .en(adv), .t_s1(fz_s1), .fade_s6(fw_s6));

	ipn_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk(clk), .en(adv), .h_s4(h_s4), .fx_s4(fx_s4), .fy_s4(fy_s4),
		.fz_s4(fz_s4), .fu_s6(fu_s6), .fv_s6(fv_s6), .fw_s6(fw_s6), .r_s12(r_s12));

	assign r_ext = ipn_pkg::ACC_W'(r_s12);

	always_comb begin
		priority if (r_ext > ipn_pkg::OUT_MAX) begin
			r_sat = ipn_pkg::OUT_MAX;
		end else if (r_ext < ipn_pkg::OUT_MIN) begin
			r_sat = ipn_pkg::OUT_MIN;
		end else begin
			r_sat = r_ext;
		end
	end

	`IPN_ASSERT_NEXT(a_enter, clk, arst_n, item.valid && item.ready, ctl_s[1].valid)
	`IPN_ASSERT_NEXT(a_hold, clk, arst_n, !adv && ctl_s[ipn_pkg::NSTG-1].valid, ctl_s[ipn_pkg::NSTG-1].valid && $stable(r_s12))
	`IPN_ASSERT_IMPL(a_load_zero, clk, arst_n, result.valid && !result.is_sample, noise_s13 == '0)

endmodule

FILE: hw/rtl/ipn_axis_split.sv
// ----------------------------------------------------------------
// ipn_axis_split
// Adds the origin to one axis, floors it and saturates the parts.
// ----------------------------------------------------------------
module ipn_axis_split #(
	parameter int FRAC_BITS = 16
) (
	input  logic signed [ipn_pkg::POS_W-1:0] pos,
	input  logic [ipn_pkg::ORG_W-1:0]        origin,
	output logic [ipn_pkg::TAB_AW-1:0]       ip_lo,
	output logic [FRAC_BITS-1:0]             frac
);

	localparam int SW = ipn_pkg::POS_W + 1;
	localparam int HI = 31 + FRAC_BITS;

	logic signed [SW-1:0] sum;
	logic                 ovf_hi;
	logic                 ovf_lo;

	assign sum = {pos[ipn_pkg::POS_W-1], pos}
		+ $signed({{(SW-ipn_pkg::ORG_W){1'b0}}, origin});

	generate
		if (HI < SW - 1) begin : g_sat
			assign ovf_hi = !sum[SW-1] && (|sum[SW-2:HI]);
			assign ovf_lo = sum[SW-1] && !(&sum[SW-2:HI]);
		end else begin : g_nosat
			assign ovf_hi = 1'b0;
			assign ovf_lo = 1'b0;
		end
	endgenerate

	always_comb begin
		priority if (ovf_hi) begin
			ip_lo = '1;
			frac  = '1;
		end else if (ovf_lo) begin
			ip_lo = '0;
			frac  = '0;
		end else begin
			ip_lo = sum[FRAC_BITS+ipn_pkg::TAB_AW-1:FRAC_BITS];
			frac  = sum[FRAC_BITS-1:0];
		end
	end

endmodule

FILE: hw/rtl/ipn_fade.sv
// ----------------------------------------------------------------
// ipn_fade
// Five-stage fade curve 6t^5-15t^4+10t^3, a multiply in each stage but the last, which clamps.
// ----------------------------------------------------------------
module ipn_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] t_s1,
	output logic [FRAC_BITS:0]   fade_s6
);

	localparam int VW = FRAC_BITS + 6;
	localparam int PW = 2 * VW;
	localparam logic signed [VW-1:0] ONE_V = VW'(1 << FRAC_BITS);
	localparam logic signed [VW-1:0] K10   = VW'(10 * (1 << FRAC_BITS));
	localparam logic signed [VW-1:0] K15   = VW'(15 * (1 << FRAC_BITS));
	localparam logic signed [PW-1:0] HALF_P = PW'(1 << (FRAC_BITS - 1));

	logic signed [VW-1:0] t_v;
	logic signed [VW-1:0] inner;
	logic signed [VW-1:0] t_s2, t_s3, t_s4;
	logic signed [PW-1:0] p_s2, p_s3, p_s4, p_s5;
	logic signed [PW-1:0] q2, q3, q4, q5;
	logic signed [VW-1:0] r1, r2, r3, r4;

	assign t_v   = $signed({{(VW-FRAC_BITS){1'b0}}, t_s1});
	assign inner = (t_v <<< 2) + (t_v <<< 1) - K15;

	assign q2 = (p_s2 + HALF_P) >>> FRAC_BITS;
	assign q3 = (p_s3 + HALF_P) >>> FRAC_BITS;
	assign q4 = (p_s4 + HALF_P) >>> FRAC_BITS;
	assign q5 = (p_s5 + HALF_P) >>> FRAC_BITS;
	assign r1 = q2[VW-1:0] + K10;
	assign r2 = q3[VW-1:0];
	assign r3 = q4[VW-1:0];
	assign r4 = q5[VW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= PW'(t_v * inner);
			t_s2 <= t_v;
			p_s3 <= PW'(t_s2 * r1);
			t_s3 <= t_s2;
			p_s4 <= PW'(t_s3 * r2);
			t_s4 <= t_s3;
			p_s5 <= PW'(t_s4 * r3);
			if (r4 < 0) begin
				fade_s6 <= '0;
			end else if (r4 > ONE_V) begin
				fade_s6 <= ONE_V[FRAC_BITS:0];
			end else begin
				fade_s6 <= r4[FRAC_BITS:0];
			end
		end
	end

endmodule

FILE: hw/rtl/ipn_perm_hash.sv
// ----------------------------------------------------------------
// ipn_perm_hash
// Three-stage corner hash over replicated permutation tables.
// ----------------------------------------------------------------
module ipn_perm_hash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  ipn_pkg::tab_wr_t              wr_s1,
	input  logic [ipn_pkg::TAB_AW-1:0]    xi_s1,
	input  logic [ipn_pkg::TAB_AW-1:0]    yi_s1,
	input  logic [ipn_pkg::TAB_AW-1:0]    zi_s1,
	output logic [ipn_pkg::BYTE_W-1:0]    h_s4 [ipn_pkg::NCORNER]
);

	localparam int AW = ipn_pkg::TAB_AW;
	localparam int DW = ipn_pkg::BYTE_W;

	logic [DW-1:0] tab_x  [ipn_pkg::TAB_DEPTH];
	logic [DW-1:0] tab_a  [ipn_pkg::TAB_DEPTH];
	logic [DW-1:0] tab_b  [ipn_pkg::TAB_DEPTH];
	logic [DW-1:0] tab_aa [ipn_pkg::TAB_DEPTH];
	logic [DW-1:0] tab_ab [ipn_pkg::TAB_DEPTH];
	logic [DW-1:0] tab_ba [ipn_pkg::TAB_DEPTH];
	logic [DW-1:0] tab_bb [ipn_pkg::TAB_DEPTH];

	ipn_pkg::tab_wr_t wr_s2, wr_s3;
	logic [AW-1:0]    yi_s2, zi_s2, zi_s3;
	logic [DW-1:0]    px0_s2, px1_s2;
	logic [DW-1:0]    pa0_s3, pa1_s3, pb0_s3, pb1_s3;
	logic [AW-1:0]    xi_n, a, a_n, b, b_n;
	logic [AW-1:0]    aa, aa_n, ab, ab_n, ba, ba_n, bb, bb_n;

	assign xi_n = xi_s1 + 8'd1;
	assign a    = px0_s2 + yi_s2;
	assign a_n  = a + 8'd1;
	assign b    = px1_s2 + yi_s2;
	assign b_n  = b + 8'd1;
	assign aa   = pa0_s3 + zi_s3;
	assign aa_n = aa + 8'd1;
	assign ab   = pa1_s3 + zi_s3;
	assign ab_n = ab + 8'd1;
	assign ba   = pb0_s3 + zi_s3;
	assign ba_n = ba + 8'd1;
	assign bb   = pb1_s3 + zi_s3;
	assign bb_n = bb + 8'd1;

	// loads write each copy as they pass its read stage
	always_ff @(posedge clk) begin
		if (en && wr_s1.wr) begin
			tab_x[wr_s1.idx] <= wr_s1.data;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_s2.wr) begin
			tab_a[wr_s2.idx] <= wr_s2.data;
			tab_b[wr_s2.idx] <= wr_s2.data;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_s3.wr) begin
			tab_aa[wr_s3.idx] <= wr_s3.data;
			tab_ab[wr_s3.idx] <= wr_s3.data;
			tab_ba[wr_s3.idx] <= wr_s3.data;
			tab_bb[wr_s3.idx] <= wr_s3.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s2 <= '0;
			wr_s3 <= '0;
		end else if (en) begin
			wr_s2 <= wr_s1;
			wr_s3 <= wr_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px0_s2  <= tab_x[xi_s1];
			px1_s2  <= tab_x[xi_n];
			yi_s2   <= yi_s1;
			zi_s2   <= zi_s1;
			pa0_s3  <= tab_a[a];
			pa1_s3  <= tab_a[a_n];
			pb0_s3  <= tab_b[b];
			pb1_s3  <= tab_b[b_n];
			zi_s3   <= zi_s2;
			h_s4[0] <= tab_aa[aa];
			h_s4[4] <= tab_aa[aa_n];
			h_s4[1] <= tab_ba[ba];
			h_s4[5] <= tab_ba[ba_n];
			h_s4[2] <= tab_ab[ab];
			h_s4[6] <= tab_ab[ab_n];
			h_s4[3] <= tab_bb[bb];
			h_s4[7] <= tab_bb[bb_n];
		end
	end

endmodule

FILE: hw/rtl/ipn_blend.sv
// ----------------------------------------------------------------
// ipn_blend
// Corner gradients and three trilinear levels, two stages a level.
// ----------------------------------------------------------------
module ipn_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ipn_pkg::BYTE_W-1:0]   h_s4 [ipn_pkg::NCORNER],
	input  logic [FRAC_BITS-1:0]         fx_s4,
	input  logic [FRAC_BITS-1:0]         fy_s4,
	input  logic [FRAC_BITS-1:0]         fz_s4,
	input  logic [FRAC_BITS:0]           fu_s6,
	input  logic [FRAC_BITS:0]           fv_s6,
	input  logic [FRAC_BITS:0]           fw_s6,
	output logic signed [FRAC_BITS+3:0]  r_s12
);

	localparam int GW = FRAC_BITS + 3;
	localparam int LW = FRAC_BITS + 4;
	localparam int DW = FRAC_BITS + 5;
	localparam int PW = 2 * DW;
	localparam logic signed [GW-1:0] ONE_G  = GW'(1 << FRAC_BITS);
	localparam logic signed [PW-1:0] HALF_P = PW'(1 << (FRAC_BITS - 1));

	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
		input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
		input logic signed [GW-1:0] z);
		logic signed [GW-1:0] u;
		logic signed [GW-1:0] v;
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		if (h[0]) u = -u;
		if (h[1]) v = -v;
		return u + v;
	endfunction

	function automatic logic signed [PW-1:0] mul_t(input logic [FRAC_BITS:0] t,
		input logic signed [LW-1:0] a, input logic signed [LW-1:0] b);
		logic signed [DW-1:0] tv;
		logic signed [DW-1:0] d;
		tv = $signed({{(DW-FRAC_BITS-1){1'b0}}, t});
		d  = DW'(b) - DW'(a);
		return PW'(tv * d);
	endfunction

	function automatic logic signed [LW-1:0] add_rnd(input logic signed [LW-1:0] a,
		input logic signed [PW-1:0] p);
		logic signed [PW-1:0] q;
		q = (p + HALF_P) >>> FRAC_BITS;
		return a + q[LW-1:0];
	endfunction

	logic signed [GW-1:0] x0, y0, z0, x1, y1, z1;
	logic signed [GW-1:0] g_s5 [ipn_pkg::NCORNER];
	logic signed [GW-1:0] g_s6 [ipn_pkg::NCORNER];
	logic signed [PW-1:0] p_s7 [4];
	logic signed [LW-1:0] a_s7 [4];
	logic signed [LW-1:0] l_s8 [4];
	logic signed [PW-1:0] p_s9 [2];
	logic signed [LW-1:0] a_s9 [2];
	logic signed [LW-1:0] m_s10 [2];
	logic signed [PW-1:0] p_s11;
	logic signed [LW-1:0] a_s11;
	logic [FRAC_BITS:0]   fv_s7, fv_s8, fw_s7, fw_s8, fw_s9, fw_s10;

	assign x0 = $signed({3'b000, fx_s4});
	assign y0 = $signed({3'b000, fy_s4});
	assign z0 = $signed({3'b000, fz_s4});
	assign x1 = x0 - ONE_G;
	assign y1 = y0 - ONE_G;
	assign z1 = z0 - ONE_G;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < ipn_pkg::NCORNER; c++) begin
				g_s5[c] <= grad(h_s4[c][3:0], c[0] ? x1 : x0, c[1] ? y1 : y0,
					c[2] ? z1 : z0);
				g_s6[c] <= g_s5[c];
			end
			for (int k = 0; k < 4; k++) begin
				p_s7[k] <= mul_t(fu_s6, LW'(g_s6[2*k]), LW'(g_s6[2*k+1]));
				a_s7[k] <= LW'(g_s6[2*k]);
				l_s8[k] <= add_rnd(a_s7[k], p_s7[k]);
			end
			for (int j = 0; j < 2; j++) begin
				p_s9[j]  <= mul_t(fv_s8, l_s8[2*j], l_s8[2*j+1]);
				a_s9[j]  <= l_s8[2*j];
				m_s10[j] <= add_rnd(a_s9[j], p_s9[j]);
			end
			p_s11  <= mul_t(fw_s10, m_s10[0], m_s10[1]);
			a_s11  <= m_s10[0];
			r_s12  <= add_rnd(a_s11, p_s11);
			fv_s7  <= fv_s6;
			fv_s8  <= fv_s7;
			fw_s7  <= fw_s6;
			fw_s8  <= fw_s7;
			fw_s9  <= fw_s8;
			fw_s10 <= fw_s9;
		end
	end

endmodule

FILE: tb/sv/improved_perlin_noise_3d_test.sv
// ----------------------------------------------------------------
// improved_perlin_noise_3d_test
// Fills the permutation table, then drives directed and random loads and
// noise samples under several origin settings with random idling on both
// channels and one long output stall. Every result is checked against a
// fixed-point noise predictor kept inside the bench.
// ----------------------------------------------------------------
module improved_perlin_noise_3d_test;

	localparam int BW = ipn_pkg::BYTE_W;
	localparam int OW = ipn_pkg::ORG_W;

	typedef struct {
		logic signed [ipn_pkg::OUT_W-1:0] noise;
		logic                             is_sample;
	} noise_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ipn_pkg::CFG_AW-1:0] cfg_idx;
	logic [ipn_pkg::ORG_W-1:0]  cfg_wdata;

	ipn_in_if  item ();
	ipn_out_if result ();

	improved_perlin_noise_3d uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	noise_result_t noise_expected [$];
	logic [ipn_pkg::BYTE_W-1:0] perm_copy [ipn_pkg::TAB_DEPTH];
	logic [ipn_pkg::ORG_W-1:0]  org_copy [3];
	int mismatches;
	bit idle_on;
	int stall_len;

	always #5 clk = ~clk;

	// fixed-point noise predictor
	function automatic longint fx_mul(longint a, longint b);
		return (a * b + 64'sd32768) >>> 16;
	endfunction

	function automatic longint fade_fx(longint t);
		longint r;
		r = fx_mul(t, 6 * t - 15 * 65536) + 10 * 65536;
		r = fx_mul(t, r);
		r = fx_mul(t, r);
		r = fx_mul(t, r);
		if (r < 0) r = 0;
		if (r > 65536) r = 65536;
		return r;
	endfunction

	function automatic longint lerp_fx(longint t, longint a, longint b);
		return a + fx_mul(t, b - a);
	endfunction

	function automatic longint grad_fx(logic [ipn_pkg::BYTE_W-1:0] hash, longint x,
		longint y, longint z);
		logic [3:0] h;
		longint u;
		longint v;
		h = hash[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic [ipn_pkg::BYTE_W-1:0] pt(int unsigned i);
		return perm_copy[i & 255];
	endfunction

	function automatic void split_axis(input logic signed [ipn_pkg::POS_W-1:0] pos,
		input logic [ipn_pkg::ORG_W-1:0] org, output int unsigned ib, output longint f);
		longint sum;
		longint ip;
		sum = longint'(pos) + longint'({40'd0, org});
		ip = sum >>> 16;
		if (ip > 64'sd2147483647) ip = 64'sd2147483647;
		if (ip < -64'sd2147483648) ip = -64'sd2147483648;
		f = sum - ip * 65536;
		if (f < 0) f = 0;
		if (f > 65535) f = 65535;
		ib = int'(ip) & 255;
	endfunction

	function automatic logic signed [ipn_pkg::OUT_W-1:0] predict_noise(
		logic signed [ipn_pkg::POS_W-1:0] px, logic signed [ipn_pkg::POS_W-1:0] py,
		logic signed [ipn_pkg::POS_W-1:0] pz);
		int unsigned xi, yi, zi, a, aa, ab, b, ba, bb;
		longint x, y, z, x1, y1, z1, fu, fv, fw, l00, l10, l01, l11, r;
		split_axis(px, org_copy[0], xi, x);
		split_axis(py, org_copy[1], yi, y);
		split_axis(pz, org_copy[2], zi, z);
		fu = fade_fx(x);
		fv = fade_fx(y);
		fw = fade_fx(z);
		a = pt(xi) + yi;
		aa = pt(a) + zi;
		ab = pt(a + 1) + zi;
		b = pt(xi + 1) + yi;
		ba = pt(b) + zi;
		bb = pt(b + 1) + zi;
		x1 = x - 65536;
		y1 = y - 65536;
		z1 = z - 65536;
		l00 = lerp_fx(fu, grad_fx(pt(aa), x, y, z), grad_fx(pt(ba), x1, y, z));
		l10 = lerp_fx(fu, grad_fx(pt(ab), x, y1, z), grad_fx(pt(bb), x1, y1, z));
		l01 = lerp_fx(fu, grad_fx(pt(aa + 1), x, y, z1), grad_fx(pt(ba + 1), x1, y, z1));
		l11 = lerp_fx(fu, grad_fx(pt(ab + 1), x, y1, z1),
			grad_fx(pt(bb + 1), x1, y1, z1));
		r = lerp_fx(fw, lerp_fx(fv, l00, l10), lerp_fx(fv, l01, l11));
		if (r > 131071) r = 131071;
		if (r < -131072) r = -131072;
		return r[ipn_pkg::OUT_W-1:0];
	endfunction

	// one item transfer, expectation queued on acceptance
	task automatic send_item(ipn_pkg::op_t op, logic [ipn_pkg::BYTE_W-1:0] idx,
		logic [ipn_pkg::BYTE_W-1:0] val, logic signed [ipn_pkg::POS_W-1:0] px,
		logic signed [ipn_pkg::POS_W-1:0] py, logic signed [ipn_pkg::POS_W-1:0] pz);
		noise_result_t e;
		int gap;
		item.valid <= 1'b1;
		item.op <= op;
		item.entry_index <= idx;
		item.entry_value <= val;
		item.pos_x <= px;
		item.pos_y <= py;
		item.pos_z <= pz;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
		if (op == ipn_pkg::OP_LOAD) begin
			perm_copy[idx] = val;
			e.noise = '0;
			e.is_sample = 1'b0;
		end else begin
			e.noise = predict_noise(px, py, pz);
			e.is_sample = 1'b1;
		end
		noise_expected.push_back(e);
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (noise_expected.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_origin(ipn_pkg::cfg_reg_t r, logic [ipn_pkg::ORG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		org_copy[r] = v;
	endtask

	function automatic logic signed [ipn_pkg::POS_W-1:0] rand_pos(bit wide);
		logic [63:0] w;
		w = {$urandom, $urandom};
		if (wide) return w[ipn_pkg::POS_W-1:0];
		return $signed({22'd0, w[25:0]}) - 48'sd33554432;
	endfunction

	task automatic send_sample(logic signed [ipn_pkg::POS_W-1:0] px,
		logic signed [ipn_pkg::POS_W-1:0] py, logic signed [ipn_pkg::POS_W-1:0] pz);
		send_item(ipn_pkg::OP_SAMPLE, BW'($urandom), BW'($urandom), px, py, pz);
	endtask

	task automatic test_table_fill();
		for (int i = 0; i < ipn_pkg::TAB_DEPTH; i++)
			send_item(ipn_pkg::OP_LOAD, BW'(i), BW'($urandom), '0, '0, '0);
	endtask

	task automatic test_directed();
		logic signed [ipn_pkg::POS_W-1:0] pmax, pmin;
		pmax = {1'b0, {(ipn_pkg::POS_W-1){1'b1}}};
		pmin = {1'b1, {(ipn_pkg::POS_W-1){1'b0}}};
		send_item(ipn_pkg::OP_LOAD, 8'd255, 8'd255, '0, '0, '0);
		send_item(ipn_pkg::OP_LOAD, 8'd0, 8'd0, '0, '0, '0);
		send_sample('0, '0, '0);
		send_sample(48'sd32768, 48'sd32768, 48'sd32768);
		send_sample(48'sd65535, 48'sd65535, 48'sd65535);
		send_sample(-48'sd1, -48'sd1, -48'sd1);
		send_sample(pmax, pmax, pmax);
		send_sample(pmin, pmin, pmin);
		send_sample(pmax, pmin, '0);
		send_sample(48'sh7FFF_FFFF_FFFF - 48'sd65535, 48'sh7FFF_FFFE_8000, -48'sd65536);
		send_sample(48'sh0000_7FFF_FFFF, 48'sh8000_0000_0000 + 48'sd1, 48'sd12345);
		send_sample(48'sd255 <<< 16, 48'sd256 <<< 16, 48'sd257 <<< 16);
		send_sample(48'sd20000, -48'sd40000, 48'sd50000);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ((i % 150) == 0) idle_on = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 9))
				0, 1: send_item(ipn_pkg::OP_LOAD, BW'($urandom), BW'($urandom),
					rand_pos(1'b1), rand_pos(1'b1), rand_pos(1'b1));
				2: send_sample(rand_pos(1'b1), rand_pos(1'b1), rand_pos(1'b1));
				default: send_sample(rand_pos(1'b0), rand_pos(1'b0), rand_pos(1'b0));
			endcase
		end
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		stall_len = 300;
		for (int i = 0; i < 60; i++)
			send_sample(rand_pos(1'b0), rand_pos(1'b0), rand_pos(1'b0));
		idle_on = 1'b1;
	endtask

	task automatic test_origins();
		write_origin(ipn_pkg::CFG_ORIGIN_X, 24'hFFFFFF);
		write_origin(ipn_pkg::CFG_ORIGIN_Y, 24'hFFFFFF);
		write_origin(ipn_pkg::CFG_ORIGIN_Z, 24'hFFFFFF);
		send_sample({1'b0, {(ipn_pkg::POS_W-1){1'b1}}}, -48'sd1, '0);
		test_random(350);
		write_origin(ipn_pkg::CFG_ORIGIN_X, OW'($urandom));
		write_origin(ipn_pkg::CFG_ORIGIN_Y, OW'($urandom));
		write_origin(ipn_pkg::CFG_ORIGIN_Z, OW'($urandom));
		test_random(350);
		write_origin(ipn_pkg::CFG_ORIGIN_X, 24'd0);
		write_origin(ipn_pkg::CFG_ORIGIN_Y, 24'h008000);
		write_origin(ipn_pkg::CFG_ORIGIN_Z, 24'd0);
		test_random(350);
	endtask

	// receiver with random hold-off per result
	initial begin
		int n;
		result.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = idle_on ? $urandom_range(0, 5) : 0;
			if (stall_len > 0) begin
				n = stall_len;
				stall_len = 0;
			end
			if (n > 0) begin
				result.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
			while (!result.valid) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		noise_result_t e;
		if (arst_n && result.valid && result.ready) begin
			if (noise_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: noise %0d sample %0b",
					result.noise_value, result.is_sample);
			end else begin
				e = noise_expected.pop_front();
				if (e.noise !== result.noise_value || e.is_sample !== result.is_sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: noise exp %0d got %0d, sample exp %0b got %0b",
							e.noise, result.noise_value, e.is_sample, result.is_sample);
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		item.valid = 1'b0;
		item.op = ipn_pkg::OP_LOAD;
		item.entry_index = '0;
		item.entry_value = '0;
		item.pos_x = '0;
		item.pos_y = '0;
		item.pos_z = '0;
		mismatches = 0;
		idle_on = 1'b1;
		stall_len = 0;
		for (int i = 0; i < 3; i++) org_copy[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_directed();
		test_random(270);
		test_backpressure();
		test_origins();
		test_random(200);
		drain();
		if (mismatches == 0 && noise_expected.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
